[rtl/core/idet_pkg.sv]
`default_nettype none

package idet_pkg;

  // Sequencer states of the minor engine (one-hot).
  typedef enum logic [3:0] {
    ENG_IDLE  = 4'b0001,
    ENG_ISSUE = 4'b0010,
    ENG_DRAIN = 4'b0100,
    ENG_STORE = 4'b1000
  } eng_state_e;

  localparam int unsigned DataW = 32;

  typedef struct packed {
    logic start;  // last element has been written, begin the expansion
    logic hold;   // result register is occupied, do not finish yet
  } eng_req_t;

  typedef struct packed {
    logic             done;  // one-cycle pulse, det is valid
    logic [DataW-1:0] det;
  } eng_rsp_t;

endpackage

`default_nettype wire

[rtl/core/idet_engine.sv]
`default_nettype none

// Minor-by-subset engine. For each column subset s the minor is built from
// the stored minors of s without one column, read back from a local memory.
module idet_engine #(
  parameter int unsigned MAX_ORDER = 8,
  localparam int unsigned OW  = $clog2(MAX_ORDER + 1),
  localparam int unsigned JW  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1,
  localparam int unsigned SD  = MAX_ORDER * MAX_ORDER,
  localparam int unsigned SAW = (SD > 1) ? $clog2(SD) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [OW-1:0]         order_i,
  input  wire idet_pkg::eng_req_t    req_i,
  output idet_pkg::eng_rsp_t         rsp_o,
  output logic [SAW-1:0]             mat_addr_o,
  input  wire logic [idet_pkg::DataW-1:0] mat_data_i
);

  localparam int unsigned MD = 2 ** MAX_ORDER;
  localparam int unsigned DW = idet_pkg::DataW;

  idet_pkg::eng_state_e state_q, state_d;

  logic [MAX_ORDER-1:0] s_q, s_d;
  logic [JW-1:0]        j_q, j_d;
  logic                 par_q, par_d;
  logic                 dr_q, dr_d;
  logic [DW-1:0]        acc_q, acc_d;

  // pipeline: read stage and product stage
  logic          v1_q, sg1_q, one1_q;
  logic          v2_q, sg2_q;
  logic [DW-1:0] p2_q;
  logic [DW-1:0] min_rd_q;

  logic [DW-1:0] minors_mem [MD];

  logic [MAX_ORDER-1:0] full;
  logic [MAX_ORDER-1:0] col_bit;
  logic [MAX_ORDER-1:0] min_addr;
  logic [OW-1:0]        pcnt;
  logic [JW-1:0]        row;
  logic                 issue_v;
  logic                 last_j;
  logic                 min_we;
  logic [DW-1:0]        factor;

  always_comb begin
    full = '0;
    pcnt = '0;
    for (int i = 0; i < MAX_ORDER; i++) begin
      full[i] = (OW'(i) < order_i);
      pcnt    = pcnt + OW'(s_q[i]);
    end
  end

  assign row      = JW'(pcnt - OW'(1));
  assign col_bit  = MAX_ORDER'(1) << j_q;
  assign min_addr = s_q ^ col_bit;
  assign issue_v  = (state_q == idet_pkg::ENG_ISSUE) && s_q[j_q];
  assign last_j   = (j_q == JW'(order_i - OW'(1)));
  assign mat_addr_o = SAW'((JW + OW)'(row) * (JW + OW)'(order_i) + (JW + OW)'(j_q));
  assign min_we   = (state_q == idet_pkg::ENG_STORE);

  always_ff @(posedge clk_i) begin
    if (min_we) begin
      minors_mem[s_q] <= acc_q;
    end
    min_rd_q <= minors_mem[min_addr];
  end

  // The empty minor is one; it is never stored.
  assign factor = one1_q ? DW'(1) : min_rd_q;

  always_ff @(posedge clk_i) begin
    p2_q <= mat_data_i * factor;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      sg1_q  <= 1'b0;
      one1_q <= 1'b0;
      v2_q   <= 1'b0;
      sg2_q  <= 1'b0;
    end else begin
      v1_q   <= issue_v;
      sg1_q  <= row[0] ^ par_q;
      one1_q <= (min_addr == '0);
      v2_q   <= v1_q;
      sg2_q  <= sg1_q;
    end
  end

  always_comb begin
    state_d = state_q;
    s_d     = s_q;
    j_d     = j_q;
    par_d   = par_q;
    dr_d    = dr_q;
    acc_d   = acc_q;
    rsp_o.done = 1'b0;
    rsp_o.det  = acc_q;
    if (v2_q) begin
      acc_d = sg2_q ? (acc_q - p2_q) : (acc_q + p2_q);
    end
    case (state_q)
      idet_pkg::ENG_IDLE: begin
        if (req_i.start) begin
          state_d = idet_pkg::ENG_ISSUE;
          s_d     = MAX_ORDER'(1);
          j_d     = '0;
          par_d   = 1'b0;
          acc_d   = '0;
        end
      end
      idet_pkg::ENG_ISSUE: begin
        if (issue_v) begin
          par_d = ~par_q;
        end
        if (last_j) begin
          state_d = idet_pkg::ENG_DRAIN;
          dr_d    = 1'b0;
        end else begin
          j_d = j_q + JW'(1);
        end
      end
      idet_pkg::ENG_DRAIN: begin
        dr_d = 1'b1;
        if (dr_q) begin
          state_d = idet_pkg::ENG_STORE;
        end
      end
      idet_pkg::ENG_STORE: begin
        if (s_q == full) begin
          if (!req_i.hold) begin
            rsp_o.done = 1'b1;
            state_d    = idet_pkg::ENG_IDLE;
          end
        end else begin
          state_d = idet_pkg::ENG_ISSUE;
          s_d     = s_q + MAX_ORDER'(1);
          j_d     = '0;
          par_d   = 1'b0;
          acc_d   = '0;
        end
      end
      default: begin
        state_d = idet_pkg::ENG_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= idet_pkg::ENG_IDLE;
      s_q     <= '0;
      j_q     <= '0;
      par_q   <= 1'b0;
      dr_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      s_q     <= s_d;
      j_q     <= j_d;
      par_q   <= par_d;
      dr_q    <= dr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

endmodule

`default_nettype wire

[rtl/core/integer_matrix_determinant.sv]
// Channel   Direction  Beat contents (lowest bit first)
// s_axis    in         tdata[31:0] element (signed)
// m_axis    out        tdata[31:0] det_value (signed), tdata[32] invertible, rest zero
// cfg       in         cfg_data_i[3:0] matrix_order
//
// Cycles: one element beat per cycle while loading. After the last element
// the input stalls while the engine does one read-multiply-accumulate per
// column of each column subset through the minors memory, and for as long as
// a waiting result beat holds the engine back; the result beat is offered in
// the cycle after the engine finishes.
// Reset clears the element count, the order (to 1) and all valid state; the
// memories are not cleared. The result register holds a waiting beat while
// loading of the next matrix goes on.
`default_nettype none

module integer_matrix_determinant #(
  parameter int unsigned MAX_ORDER = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // [31:0] element
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [39:0]      m_axis_tdata_o,   // [31:0] det_value, [32] invertible
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_data_i        // [3:0] matrix_order
);

  localparam int unsigned OW  = $clog2(MAX_ORDER + 1);
  localparam int unsigned SD  = MAX_ORDER * MAX_ORDER;
  localparam int unsigned SAW = (SD > 1) ? $clog2(SD) : 1;
  localparam int unsigned CW  = $clog2(SD + 1);
  localparam int unsigned TW  = 2 * OW;
  localparam int unsigned DW  = idet_pkg::DataW;

  logic [OW-1:0]  order_q, order_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           busy_q, busy_d;
  logic           out_valid_q, out_valid_d;
  logic [DW-1:0]  out_det_q;

  logic [DW-1:0]  mat_mem [SD];
  logic [DW-1:0]  mat_rd_q;
  logic [SAW-1:0] mat_addr;

  idet_pkg::eng_req_t eng_req;
  idet_pkg::eng_rsp_t eng_rsp;

  logic           in_beat;
  logic           last_elem;
  logic [TW-1:0]  total;

  // The order register saturates: zero loads as one, anything above the
  // largest supported order loads as that order.
  always_comb begin
    if (cfg_data_i == 4'd0) begin
      order_d = OW'(1);
    end else if (cfg_data_i > 4'(MAX_ORDER)) begin
      order_d = OW'(MAX_ORDER);
    end else begin
      order_d = OW'(cfg_data_i);
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !busy_q;
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;
  assign total           = TW'(order_q) * TW'(order_q);
  assign last_elem       = ((TW + CW)'(cnt_q) + (TW + CW)'(1)) == (TW + CW)'(total);

  // Elements are stored at their row-major position, which is the count.
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      mat_mem[SAW'(cnt_q)] <= s_axis_tdata_i;
    end
    mat_rd_q <= mat_mem[mat_addr];
  end

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (in_beat) begin
      if (last_elem) begin
        cnt_d  = '0;
        busy_d = 1'b1;
      end else begin
        cnt_d = cnt_q + CW'(1);
      end
    end
    if (eng_rsp.done) begin
      busy_d = 1'b0;
    end
    // A new order restarts loading.
    if (cfg_valid_i) begin
      cnt_d = '0;
    end
  end

  assign eng_req = '{start: in_beat && last_elem, hold: out_valid_q && !m_axis_tready_i};

  idet_engine #(
    .MAX_ORDER (MAX_ORDER)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .order_i    (order_q),
    .req_i      (eng_req),
    .rsp_o      (eng_rsp),
    .mat_addr_o (mat_addr),
    .mat_data_i (mat_rd_q)
  );

  // Output register; the engine only finishes when it is free or draining.
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (eng_rsp.done) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_rsp.done) begin
      out_det_q <= eng_rsp.det;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, (out_det_q != '0), out_det_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q     <= OW'(1);
      cnt_q       <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        order_q <= order_d;
      end
      cnt_q       <= cnt_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/idet_checker.sv]
`default_nettype none

module idet_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [39:0] m_axis_tdata_o,
  input wire logic        cfg_ready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  a_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[32] == (m_axis_tdata_o[31:0] != 32'd0)))
    else $error("invertible flag disagrees with determinant");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[39:33] == 7'd0) && cfg_ready_o)
    else $error("padding bits set or configuration port blocked");

endmodule

bind integer_matrix_determinant idet_checker u_idet_checker (.*);

`default_nettype wire

[tb/sv/integer_matrix_determinant_test.sv]
`timescale 1ns / 1ps

module integer_matrix_determinant_test;

  localparam int unsigned MaxOrder   = 8;
  localparam int unsigned IdleLimit  = 20000;
  localparam int unsigned RandMats   = 120;
  localparam logic [3:0]  OrderZero  = 4'd0;
  localparam logic [3:0]  OrderOne   = 4'd1;
  localparam logic [3:0]  OrderTwo   = 4'd2;
  localparam logic [3:0]  OrderThree = 4'd3;
  localparam logic [3:0]  OrderMax   = 4'd8;
  localparam logic [3:0]  OrderOver  = 4'd15;

  // One determinant result as it travels on the output stream.
  typedef struct packed {
    logic                       invertible;
    logic [idet_pkg::DataW-1:0] det_value;
  } det_beat_t;

  // A directed row: one element, and where the value is obvious, the result it completes.
  typedef struct packed {
    logic [idet_pkg::DataW-1:0] element;
    logic                       known;
    det_beat_t                  beat;
  } element_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;    // [31:0] element
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;         // [31:0] det_value, [32] invertible
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_data_i = OrderOne;  // [3:0] matrix_order

  integer_matrix_determinant #(.MAX_ORDER(MaxOrder)) i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state: the order register, the matrix being loaded, the minors table.
  logic [3:0]                 order_reg;
  int unsigned                loaded_count;
  logic [idet_pkg::DataW-1:0] matrix_mem [MaxOrder*MaxOrder];
  logic [idet_pkg::DataW-1:0] minor_tab [1 << MaxOrder];
  det_beat_t                  pending_dets [$];

  int unsigned mismatch_count = 0;
  int unsigned det_count = 0;
  int unsigned element_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned order_hits [MaxOrder+1];
  bit          stall_random = 1'b0;
  bit          hold_output = 1'b0;
  bit          feed_random = 1'b0;

  function automatic int unsigned live_order();
    if (order_reg == 4'd0) begin
      return 1;
    end
    if (order_reg > MaxOrder) begin
      return MaxOrder;
    end
    return order_reg;
  endfunction

  // Determinant by minors over column subsets, expanded along the last row of each subset.
  function automatic logic [idet_pkg::DataW-1:0] subset_det(int unsigned n);
    int unsigned                row;
    int unsigned                col_pos;
    logic [idet_pkg::DataW-1:0] acc;
    logic [idet_pkg::DataW-1:0] term;
    minor_tab[0] = 1;
    for (int unsigned s = 1; s < (1 << n); s++) begin
      row = $countones(s) - 1;
      acc = '0;
      col_pos = 0;
      for (int unsigned j = 0; j < n; j++) begin
        if (s[j]) begin
          term = matrix_mem[row*n + j] * minor_tab[s ^ (1 << j)];
          acc = ((row + col_pos) % 2 == 1) ? acc - term : acc + term;
          col_pos++;
        end
      end
      minor_tab[s] = acc;
    end
    return minor_tab[(1 << n) - 1];
  endfunction

  // Called for each accepted element; returns 1 with the result when a matrix completes.
  function automatic bit absorb_element(logic [idet_pkg::DataW-1:0] value,
                                        output det_beat_t beat);
    int unsigned n;
    n = live_order();
    matrix_mem[loaded_count] = value;
    loaded_count++;
    if (loaded_count < n*n) begin
      return 1'b0;
    end
    loaded_count = 0;
    beat.det_value = subset_det(n);
    beat.invertible = (beat.det_value != '0);
    order_hits[n]++;
    return 1'b1;
  endfunction

  // Offers one element and waits for its acceptance. Valid stays high afterwards,
  // so back-to-back elements follow without a gap; an idle cycle lowers it.
  task automatic drive_element(logic [idet_pkg::DataW-1:0] value, output bit completes,
                               output det_beat_t beat);
    while (feed_random && ($urandom_range(99) < 24)) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= value;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready_o);
    element_count++;
    completes = absorb_element(value, beat);
  endtask

  task automatic send_element(logic [idet_pkg::DataW-1:0] value);
    det_beat_t beat;
    bit        completes;
    drive_element(value, completes, beat);
    if (completes) begin
      pending_dets.push_back(beat);
    end
  endtask

  // Waits for every result, then lets the longest expansion pass before touching the register.
  task automatic write_order(logic [3:0] value);
    s_axis_tvalid_i <= 1'b0;
    while (pending_dets.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (3000) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    order_reg = value;
    loaded_count = 0;
  endtask

  function automatic logic [idet_pkg::DataW-1:0] random_element(int unsigned flavor);
    case (flavor % 4)
      0: begin
        return $urandom;
      end
      1: begin
        return $urandom_range(8) - 4;
      end
      2: begin
        return ($urandom_range(1)) ? 32'h8000_0000 : 32'h7fff_ffff;
      end
      default: begin
        return $urandom_range(200) - 100;
      end
    endcase
  endfunction

  // Receiver side: random stalls, or a long hold while the sender keeps offering elements.
  always @(posedge clk_i) begin
    if (hold_output) begin
      m_axis_tready_i <= 1'b0;
    end else if (stall_random) begin
      m_axis_tready_i <= ($urandom_range(99) >= 24);
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Output checker, compared against the oldest expected result.
  always @(posedge clk_i) begin
    det_beat_t got;
    det_beat_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = det_beat_t'(m_axis_tdata_o[32:0]);
      det_count++;
      if (pending_dets.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result beat det=%0d", $signed(got.det_value));
        end
      end else begin
        want = pending_dets.pop_front();
        if (got.det_value !== want.det_value || got.invertible !== want.invertible
            || m_axis_tdata_o[39:33] !== '0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result mismatch: det exp %0d got %0d, invertible exp %0b got %0b",
                     $signed(want.det_value), $signed(got.det_value),
                     want.invertible, got.invertible);
          end
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles > IdleLimit) begin
      $display("integer_matrix_determinant_test: errors");
      $finish;
    end
  end

  // Directed rows. Order 1 is the reset value; the known results are read off directly.
  element_row_t directed_rows [] = '{
    '{32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000}},
    '{32'h7fff_ffff, 1'b1, '{1'b1, 32'h7fff_ffff}},
    '{32'h8000_0000, 1'b1, '{1'b1, 32'h8000_0000}},
    '{32'hffff_ffff, 1'b1, '{1'b1, 32'hffff_ffff}},
    '{32'h0000_0001, 1'b1, '{1'b1, 32'h0000_0001}}
  };

  initial begin
    det_beat_t   beat;
    bit          completes;
    logic [3:0]  order_plan [] = '{OrderTwo, OrderThree, OrderMax, OrderZero, OrderOver,
                                   OrderOne};
    int unsigned n;
    int unsigned flavor;
    for (int i = 0; i <= MaxOrder; i++) begin
      order_hits[i] = 0;
    end
    order_reg = OrderOne;
    loaded_count = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed order-1 rows; a typed-in result is used where given, else the predictor's.
    foreach (directed_rows[i]) begin
      drive_element(directed_rows[i].element, completes, beat);
      if (completes) begin
        pending_dets.push_back(directed_rows[i].known ? directed_rows[i].beat : beat);
      end
    end

    // Order 2: an overflowing product pair, the identity, and a singular matrix.
    write_order(OrderTwo);
    send_element(32'h8000_0000); send_element(32'h7fff_ffff);
    send_element(32'h7fff_ffff); send_element(32'h8000_0000);
    send_element(1); send_element(0); send_element(0); send_element(1);
    send_element(2); send_element(4); send_element(1); send_element(2);
    // Half a matrix, then a register write throws it away.
    send_element(5); send_element(6);
    write_order(OrderThree);
    for (int i = 0; i < 9; i++) begin
      send_element(i + 1);
    end

    // Random matrices at order settings 2, 3, 8, 0, 15 and 1, extremes included.
    stall_random = 1'b1;
    feed_random = 1'b1;
    foreach (order_plan[k]) begin
      write_order(order_plan[k]);
      n = live_order();
      for (int m = 0; m < ((n >= 7) ? 4 : RandMats / n); m++) begin
        flavor = $urandom_range(3);
        for (int e = 0; e < n*n; e++) begin
          send_element(random_element(flavor));
        end
        // Occasionally load part of a matrix and abandon it through a register write.
        if (m == 2 && n > 1) begin
          send_element($urandom);
          write_order(order_plan[k]);
        end
      end
    end

    // Long receiver hold while order-1 matrices keep coming, so the block backs up.
    write_order(OrderOne);
    fork
      begin
        hold_output = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_output = 1'b0;
      end
      begin
        for (int i = 0; i < 12; i++) begin
          send_element($urandom);
        end
      end
    join

    // A calm stretch with no idling on either side.
    stall_random = 1'b0;
    feed_random = 1'b0;
    write_order(OrderTwo);
    for (int i = 0; i < 200; i++) begin
      send_element(random_element(i));
    end
    s_axis_tvalid_i <= 1'b0;

    while (pending_dets.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (3000) @(posedge clk_i);

    $display("Sent %0d elements, checked %0d determinants; per order 1..8: %0d %0d %0d %0d %0d %0d %0d %0d",
             element_count, det_count, order_hits[1], order_hits[2], order_hits[3],
             order_hits[4], order_hits[5], order_hits[6], order_hits[7], order_hits[8]);
    $display("Orders 0 and 15 were folded to 1 and 8; %0d mismatches.", mismatch_count);
    if (mismatch_count == 0 && pending_dets.size() == 0) begin
      $display("integer_matrix_determinant_test: clean");
    end else begin
      $display("integer_matrix_determinant_test: errors");
    end
    $finish;
  end

endmodule

[integer_matrix_determinant.f]
rtl/core/idet_pkg.sv
rtl/core/idet_engine.sv
rtl/core/integer_matrix_determinant.sv
rtl/core/idet_checker.sv
tb/sv/integer_matrix_determinant_test.sv
